FILE: rtl/voxel_box_occupancy_grid_assert.svh
// ----------------------------------------------------------------------------
// Voxel box occupancy grid assertion macros
// Clocked assertion shorthands, all disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef VOXEL_BOX_OCCUPANCY_GRID_ASSERT_SVH
`define VOXEL_BOX_OCCUPANCY_GRID_ASSERT_SVH

// property must hold at every clock edge out of reset
`define VBOG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define VBOG_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/vbog_pkg.sv
// ----------------------------------------------------------------------------
// Voxel box occupancy grid package
// Field widths, command and register codes, defaults and the corner-to-cell
// conversion shared by the grid files.
// ----------------------------------------------------------------------------
package vbog_pkg;

	localparam int GRID_DIM_DEF   = 64;
	localparam int CELL_SHIFT_DEF = 7;

	localparam int COORD_W    = 16;
	localparam int CELL_W     = 6;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOX   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z  = 3'd5;

	localparam logic [CELL_W-1:0]  CELLS_RESET  = 6'd63;
	localparam logic [COORD_W-1:0] ORIGIN_RESET = 16'd0;

	// clamped cell indices of one box, both corners
	typedef struct packed {
		logic [CELL_W-1:0] x0;
		logic [CELL_W-1:0] y0;
		logic [CELL_W-1:0] z0;
		logic [CELL_W-1:0] x1;
		logic [CELL_W-1:0] y1;
		logic [CELL_W-1:0] z1;
	} box_bounds_t;

	// (coord - origin) floored to a cell, clamped to 0..limit
	function automatic logic [CELL_W-1:0] to_cell(
		input logic [COORD_W-1:0] coord,
		input logic [COORD_W-1:0] origin,
		input logic [CELL_W-1:0]  limit,
		input int                 shift
	);
		logic [COORD_W:0]   diff;
		logic [COORD_W-1:0] cidx;
		diff = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
		cidx = diff[COORD_W-1:0] >> shift;
		if (diff[COORD_W]) begin
			return '0;
		end else if (cidx > COORD_W'(limit)) begin
			return limit;
		end else begin
			return CELL_W'(cidx);
		end
	endfunction

endpackage

FILE: rtl/vbog_if.sv
// ----------------------------------------------------------------------------
// Voxel box occupancy grid channels
// Valid/ready channels for command items and for results.
// ----------------------------------------------------------------------------
interface vbog_item_if;
	logic                              valid;
	logic                              ready;
	logic [vbog_pkg::CMD_W-1:0]        command;
	logic signed [vbog_pkg::COORD_W-1:0] box_min_x;
	logic signed [vbog_pkg::COORD_W-1:0] box_min_y;
	logic signed [vbog_pkg::COORD_W-1:0] box_min_z;
	logic signed [vbog_pkg::COORD_W-1:0] box_max_x;
	logic signed [vbog_pkg::COORD_W-1:0] box_max_y;
	logic signed [vbog_pkg::COORD_W-1:0] box_max_z;
	logic [vbog_pkg::CELL_W-1:0]       cell_x;
	logic [vbog_pkg::CELL_W-1:0]       cell_y;
	logic [vbog_pkg::CELL_W-1:0]       cell_z;

	modport source (
		output valid, command, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z, cell_x, cell_y, cell_z,
		input  ready
	);
	modport sink (
		input  valid, command, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z, cell_x, cell_y, cell_z,
		output ready
	);
endinterface

interface vbog_result_if;
	logic valid;
	logic ready;
	logic occupied;
	logic done_res;

	modport source (output valid, occupied, done_res, input ready);
	modport sink (input valid, occupied, done_res, output ready);
endinterface

FILE: rtl/vbog_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address for read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module vbog_ram #(
	parameter int  WIDTH = 1,
	parameter int  DEPTH = 2,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             re,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: rtl/voxel_box_occupancy_grid.sv
// ----------------------------------------------------------------------------
// Voxel box occupancy grid
// 3-D one-bit occupancy grid: clear, fill an inclusive box, query one cell.
// Rows along z are stored one word per (x, y) in a single-port RAM.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when          | payload
//  --------+-----+------------------------+-------------------------------------
//  cfg     | in  | cfg_we high            | cfg_index, cfg_data
//  item    | in  | item.valid & ready     | command, box corners, cell index
//  result  | out | result.valid & ready   | occupied, done_res
//
//  Query: accept, RAM read, bit select, result register.
//  Clear: all GRID_DIM*GRID_DIM z rows are written, one z row per cycle.
//  Box: convert, set up, then a read and a write-back per (x, y) footprint row; each row is a RAM
//  read-modify-write, so the single RAM port sets the pace.
//  After reset a clearing pass over all GRID_DIM*GRID_DIM rows runs with item.ready low.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and stalls only at its own completion.
// ----------------------------------------------------------------------------
module voxel_box_occupancy_grid #(
	parameter int GRID_DIM   = vbog_pkg::GRID_DIM_DEF,
	parameter int CELL_SHIFT = vbog_pkg::CELL_SHIFT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vbog_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vbog_pkg::CFG_DATA_W-1:0] cfg_data,
	vbog_item_if.sink                       item,
	vbog_result_if.source                   result
);

	`include "voxel_box_occupancy_grid_assert.svh"

	localparam int CW   = $clog2(GRID_DIM);
	localparam int ROWS = GRID_DIM * GRID_DIM;
	localparam int RAW  = $clog2(ROWS);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_CONV    = 9'b000000010,
		S_BOXINIT = 9'b000000100,
		S_BOX_RD  = 9'b000001000,
		S_BOX_WR  = 9'b000010000,
		S_QUERY   = 9'b000100000,
		S_QDATA   = 9'b001000000,
		S_CLEAR   = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [vbog_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [vbog_pkg::CELL_W-1:0]  cells_x_q, cells_y_q, cells_z_q;

	// captured item
	logic [vbog_pkg::CMD_W-1:0]   cmd_q;
	logic [vbog_pkg::COORD_W-1:0] min_x_q, min_y_q, min_z_q;
	logic [vbog_pkg::COORD_W-1:0] max_x_q, max_y_q, max_z_q;
	logic [CW-1:0]                qx_q, qy_q, qz_q;
	logic                         qhit_q;

	// box walk
	vbog_pkg::box_bounds_t bnd_q;
	logic [CW-1:0]         xcnt_q, xend_q, ycnt_q, ystart_q, yend_q;
	logic [GRID_DIM-1:0]   zmask_q;
	logic [GRID_DIM-1:0]   zmask_d;
	logic                  box_empty;

	logic [RAW-1:0] clr_cnt_q;
	logic           clr_resp_q;
	logic           occ_q;
	logic           res_valid_q;
	logic           res_occ_q;
	logic           res_take;

	logic                ram_re, ram_we;
	logic [RAW-1:0]      ram_addr;
	logic [GRID_DIM-1:0] ram_wdata, ram_rdata;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= vbog_pkg::ORIGIN_RESET;
			origin_y_q <= vbog_pkg::ORIGIN_RESET;
			origin_z_q <= vbog_pkg::ORIGIN_RESET;
			cells_x_q  <= vbog_pkg::CELLS_RESET;
			cells_y_q  <= vbog_pkg::CELLS_RESET;
			cells_z_q  <= vbog_pkg::CELLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vbog_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				vbog_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				vbog_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
				vbog_pkg::REG_CELLS_X:  cells_x_q  <= cfg_data[vbog_pkg::CELL_W-1:0];
				vbog_pkg::REG_CELLS_Y:  cells_y_q  <= cfg_data[vbog_pkg::CELL_W-1:0];
				vbog_pkg::REG_CELLS_Z:  cells_z_q  <= cfg_data[vbog_pkg::CELL_W-1:0];
				default: ;
			endcase
		end
	end

	assign item.ready      = (state_q == S_IDLE);
	assign result.valid    = res_valid_q;
	assign result.occupied = res_occ_q;
	assign result.done_res = 1'b1;

	assign res_take = (state_q == S_DONE) && (!res_valid_q || result.ready);

	// box is empty when a corner pair is inverted or starts beyond storage
	assign box_empty = (bnd_q.x0 > bnd_q.x1) || (bnd_q.y0 > bnd_q.y1) ||
	                   (bnd_q.z0 > bnd_q.z1) ||
	                   (32'(bnd_q.x0) >= GRID_DIM) || (32'(bnd_q.y0) >= GRID_DIM) ||
	                   (32'(bnd_q.z0) >= GRID_DIM);

	always_comb begin
		for (int k = 0; k < GRID_DIM; k++) begin
			zmask_d[k] = (k >= int'(bnd_q.z0)) && (k <= int'(bnd_q.z1));
		end
	end

	// captured payload, converted bounds and box-walk setup, no reset
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_q   <= item.command;
			min_x_q <= item.box_min_x;
			min_y_q <= item.box_min_y;
			min_z_q <= item.box_min_z;
			max_x_q <= item.box_max_x;
			max_y_q <= item.box_max_y;
			max_z_q <= item.box_max_z;
			qhit_q  <= (32'(item.cell_x) < GRID_DIM) && (32'(item.cell_y) < GRID_DIM) &&
			           (32'(item.cell_z) < GRID_DIM);
			if ((32'(item.cell_x) < GRID_DIM) && (32'(item.cell_y) < GRID_DIM) &&
			    (32'(item.cell_z) < GRID_DIM)) begin
				qx_q <= CW'(item.cell_x);
				qy_q <= CW'(item.cell_y);
				qz_q <= CW'(item.cell_z);
			end else begin
				qx_q <= '0;
				qy_q <= '0;
				qz_q <= '0;
			end
		end
		if (state_q == S_CONV) begin
			bnd_q.x0 <= vbog_pkg::to_cell(min_x_q, origin_x_q, cells_x_q, CELL_SHIFT);
			bnd_q.y0 <= vbog_pkg::to_cell(min_y_q, origin_y_q, cells_y_q, CELL_SHIFT);
			bnd_q.z0 <= vbog_pkg::to_cell(min_z_q, origin_z_q, cells_z_q, CELL_SHIFT);
			bnd_q.x1 <= vbog_pkg::to_cell(max_x_q, origin_x_q, cells_x_q, CELL_SHIFT);
			bnd_q.y1 <= vbog_pkg::to_cell(max_y_q, origin_y_q, cells_y_q, CELL_SHIFT);
			bnd_q.z1 <= vbog_pkg::to_cell(max_z_q, origin_z_q, cells_z_q, CELL_SHIFT);
		end
		if (state_q == S_BOXINIT) begin
			zmask_q  <= zmask_d;
			ystart_q <= CW'(bnd_q.y0);
			xend_q   <= (32'(bnd_q.x1) >= GRID_DIM) ? CW'(GRID_DIM - 1) : CW'(bnd_q.x1);
			yend_q   <= (32'(bnd_q.y1) >= GRID_DIM) ? CW'(GRID_DIM - 1) : CW'(bnd_q.y1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			clr_resp_q  <= 1'b0;
			xcnt_q      <= '0;
			ycnt_q      <= '0;
			occ_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_occ_q   <= 1'b0;
		end else begin
			if (res_take) begin
				res_valid_q <= 1'b1;
				res_occ_q   <= occ_q;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					occ_q <= 1'b0;
					if (item.valid) begin
						case (item.command)
							vbog_pkg::CMD_CLEAR: begin
								clr_resp_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							vbog_pkg::CMD_BOX:   state_q <= S_CONV;
							vbog_pkg::CMD_QUERY: state_q <= S_QUERY;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_CONV: state_q <= S_BOXINIT;
				S_BOXINIT: begin
					xcnt_q  <= CW'(bnd_q.x0);
					ycnt_q  <= CW'(bnd_q.y0);
					state_q <= box_empty ? S_DONE : S_BOX_RD;
				end
				S_BOX_RD: state_q <= S_BOX_WR;
				S_BOX_WR: begin
					if (ycnt_q == yend_q) begin
						ycnt_q <= ystart_q;
						if (xcnt_q == xend_q) begin
							state_q <= S_DONE;
						end else begin
							xcnt_q  <= xcnt_q + 1'b1;
							state_q <= S_BOX_RD;
						end
					end else begin
						ycnt_q  <= ycnt_q + 1'b1;
						state_q <= S_BOX_RD;
					end
				end
				S_QUERY: state_q <= S_QDATA;
				S_QDATA: begin
					occ_q   <= qhit_q && ram_rdata[qz_q];
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					if (clr_cnt_q == RAW'(ROWS - 1)) begin
						clr_cnt_q  <= '0;
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? S_DONE : S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// RAM port: one access per cycle; box rows are read, then written back
	always_comb begin
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = RAW'(RAW'(xcnt_q) * RAW'(GRID_DIM) + RAW'(ycnt_q));
		ram_wdata = ram_rdata | zmask_q;
		case (state_q)
			S_BOX_RD: ram_re = 1'b1;
			S_BOX_WR: ram_we = 1'b1;
			S_QUERY: begin
				ram_re   = 1'b1;
				ram_addr = RAW'(RAW'(qx_q) * RAW'(GRID_DIM) + RAW'(qy_q));
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = '0;
			end
			default: ;
		endcase
	end

	vbog_ram #(
		.WIDTH (GRID_DIM),
		.DEPTH (ROWS)
	) u_grid_ram (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	`VBOG_ASSERT(a_rmw_same_row, (state_q == S_BOX_WR) |-> (ram_addr == $past(ram_addr)), "box write-back row differs from row read")
	`VBOG_ASSERT(a_query_read, (state_q == S_QUERY) |=> (state_q == S_QDATA), "query read not followed by bit select")
	`VBOG_ASSERT(a_box_in_bounds, (state_q == S_BOX_RD) |-> (32'(xcnt_q) < GRID_DIM && 32'(ycnt_q) < GRID_DIM && ycnt_q <= yend_q && xcnt_q <= xend_q), "box walk left its bounds")
	`VBOG_ASSERT(a_clear_from_zero, (state_q == S_CLEAR && $past(state_q) != S_CLEAR) |-> (clr_cnt_q == '0), "clear sweep did not start at row zero")

endmodule
